[hdl/eqc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eqc_pkg: shared types and constants
// Widths, register map, payload structs and cell state for the
// equilibrium current unit.
// ----------------------------------------------------------------------------
package eqc_pkg;

  // Fixed-point format of every value field.
  localparam int unsigned ValueW = 24;
  localparam int unsigned FracW  = 16;

  // Common numerator width of the three division lanes (largest is Q).
  localparam int unsigned NumW  = 2 * ValueW + 2 * FracW + 1;
  localparam int unsigned DenAW = ValueW + 1;      // load or 2R
  localparam int unsigned DenPW = 2 * ValueW + 2;  // 4R^2
  localparam int unsigned DenQW = 2 * ValueW;      // R*load
  localparam int unsigned RootW = ValueW + FracW;  // sqrt result and A
  localparam int unsigned RadW  = 2 * RootW;       // sqrt radicand

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [ValueW-1:0] CurMax = {1'b0, {(ValueW - 1){1'b1}}};
  localparam logic [ValueW-1:0] OneFix = ValueW'(1 << FracW);

  typedef enum logic [1:0] {
    MODE_BUCK       = 2'd0,
    MODE_BOOST      = 2'd1,
    MODE_BUCK_BOOST = 2'd2,
    MODE_TSBB       = 2'd3
  } eqc_mode_e;

  localparam logic [2:0] RegMode    = 3'd0;
  localparam logic [2:0] RegUseEst  = 3'd1;
  localparam logic [2:0] RegNomLoad = 3'd2;
  localparam logic [2:0] RegSeries  = 3'd3;
  localparam logic [2:0] RegVref    = 3'd4;

  typedef struct packed {
    logic [ValueW-1:0] input_voltage;
    logic [ValueW-1:0] estimated_load;
  } eqc_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] equilibrium_current;
    logic [ValueW-1:0]        equilibrium_voltage;
    logic                     saturated;
  } eqc_out_t;

  // Control carried along with each transaction.
  typedef struct packed {
    logic              valid;
    logic              buck;
    logic              sat;
    logic [ValueW-1:0] vref;
  } eqc_side_t;

  // One step of the three restoring divisions. Each shift register holds the
  // numerator bits still to be consumed on top and the quotient bits below.
  typedef struct packed {
    eqc_side_t        side;
    logic [NumW-1:0]  sh_a;
    logic [DenAW-1:0] rem_a;
    logic [DenAW-1:0] den_a;
    logic [NumW-1:0]  sh_p;
    logic [DenPW-1:0] rem_p;
    logic [DenPW-1:0] den_p;
    logic [NumW-1:0]  sh_q;
    logic [DenQW-1:0] rem_q;
    logic [DenQW-1:0] den_q;
  } eqc_div_t;

  // One step of the restoring square root.
  typedef struct packed {
    eqc_side_t        side;
    logic [RootW-1:0] quo_a;
    logic [RadW-1:0]  sh;
    logic [RootW:0]   rem;
    logic [RootW-1:0] root;
  } eqc_sqrt_t;

endpackage
`default_nettype wire

[hdl/converter_equilibrium_current_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// converter_equilibrium_current_unit: DC-DC converter operating point
// Computes the steady-state inductor current and output voltage per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Program converter_mode, use_estimated_load, nominal_load,
//   series_resistance and reference_voltage over the APB port (byte address
//   4*index) while no transaction is in flight. Reads return the register.
//   Issue a transaction by raising start_i with item_i; busy_o stays low, so
//   one transaction is taken every cycle.
//   Each transaction yields one result on result_o, marked by done_o for a
//   single cycle. The receiver cannot stall; results leave in issue order.
// Pipeline and throughput:
//   The pipeline is one product stage, a row of NumW division cells (one
//   quotient bit per cell, three lanes side by side), one subtract stage,
//   a row of RootW square-root cells (one root bit per cell) and the output
//   register. Throughput is one transaction per cycle.
// Reset:
//   Registers return to their defaults and all in-flight transactions drop.
// ----------------------------------------------------------------------------
module converter_equilibrium_current_unit import eqc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // APB configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready,
  // transaction in
  input  wire logic             start_i,
  input  wire eqc_in_t          item_i,
  output logic                  busy_o,
  // transaction out
  output logic                  done_o,
  output eqc_out_t              result_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  eqc_mode_e         mode_q;
  logic              use_est_q;
  logic [ValueW-1:0] nominal_q;
  logic [ValueW-1:0] series_q;
  logic [ValueW-1:0] vref_q;
  logic              wr_en;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_BUCK;
      use_est_q <= 1'b0;
      nominal_q <= OneFix;
      series_q  <= OneFix;
      vref_q    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        RegMode:    mode_q    <= eqc_mode_e'(pwdata[1:0]);
        RegUseEst:  use_est_q <= pwdata[0];
        RegNomLoad: nominal_q <= pwdata[ValueW-1:0];
        RegSeries:  series_q  <= pwdata[ValueW-1:0];
        RegVref:    vref_q    <= pwdata[ValueW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMode:    prdata = DataW'(mode_q);
      RegUseEst:  prdata = DataW'(use_est_q);
      RegNomLoad: prdata = DataW'(nominal_q);
      RegSeries:  prdata = DataW'(series_q);
      RegVref:    prdata = DataW'(vref_q);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Product stage: pick the load, form numerators and divisors
  // --------------------------------------------------------------------------
  logic                accept;
  logic [ValueW-1:0]   load;
  logic                buck;
  logic [ValueW:0]     w_fac;
  logic [2*ValueW-1:0] uu;
  logic [2*ValueW-1:0] rr;
  logic [2*ValueW-1:0] rl;
  logic [2*ValueW:0]   ww;
  eqc_div_t            init_d, init_q;
  logic                init_valid_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  always_comb begin
    load  = use_est_q ? item_i.estimated_load : nominal_q;
    buck  = (mode_q == MODE_BUCK);
    // Boost uses Vref^2, both buck-boost modes Vref*(Vref+u).
    w_fac = (mode_q == MODE_BOOST) ? {1'b0, vref_q}
                                   : {1'b0, vref_q} + {1'b0, item_i.input_voltage};
    uu    = item_i.input_voltage * item_i.input_voltage;
    rr    = series_q * series_q;
    rl    = series_q * load;
    ww    = vref_q * w_fac;

    init_d.side.valid = accept;
    init_d.side.buck  = buck;
    init_d.side.sat   = (load == '0) | (~buck & (series_q == '0));
    init_d.side.vref  = vref_q;

    // Lane A: Vref/load in buck mode, else u/(2R).
    init_d.sh_a  = NumW'({(buck ? vref_q : item_i.input_voltage), FracW'(0)});
    init_d.den_a = buck ? {1'b0, load} : {series_q, 1'b0};
    init_d.rem_a = '0;
    // Lane P: u^2 / (4R^2).
    init_d.sh_p  = NumW'({uu, (2 * FracW)'(0)});
    init_d.den_p = {rr, 2'b00};
    init_d.rem_p = '0;
    // Lane Q: W / (R*load).
    init_d.sh_q  = {ww, (2 * FracW)'(0)};
    init_d.den_q = rl;
    init_d.rem_q = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_valid_q <= 1'b0;
    end else begin
      init_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    init_q <= init_d;
  end

  // --------------------------------------------------------------------------
  // Division row
  // --------------------------------------------------------------------------
  eqc_div_t div_s [NumW+1];

  always_comb begin
    div_s[0]            = init_q;
    div_s[0].side.valid = init_valid_q;
  end

  for (genvar i = 0; i < NumW; i++) begin : g_div
    eqc_div_cell u_cell (
      .clk_i,
      .rst_ni,
      .d_i (div_s[i]),
      .q_o (div_s[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Subtract stage: val = P - Q, clamped at zero
  // --------------------------------------------------------------------------
  eqc_div_t        div_last;
  logic [NumW-1:0] pq_diff;
  eqc_sqrt_t       rad_d, rad_q;
  logic            rad_valid_q;

  always_comb begin
    div_last = div_s[NumW];
    pq_diff  = div_last.sh_p - div_last.sh_q;

    rad_d.side  = div_last.side;
    rad_d.quo_a = div_last.sh_a[RootW-1:0];
    rad_d.sh    = (div_last.sh_p > div_last.sh_q) ? pq_diff[RadW-1:0] : '0;
    rad_d.rem   = '0;
    rad_d.root  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_valid_q <= 1'b0;
    end else begin
      rad_valid_q <= div_last.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
  end

  // --------------------------------------------------------------------------
  // Square-root row
  // --------------------------------------------------------------------------
  eqc_sqrt_t sq_s [RootW+1];

  always_comb begin
    sq_s[0]            = rad_q;
    sq_s[0].side.valid = rad_valid_q;
  end

  for (genvar j = 0; j < RootW; j++) begin : g_sqrt
    eqc_sqrt_cell u_cell (
      .clk_i,
      .rst_ni,
      .d_i (sq_s[j]),
      .q_o (sq_s[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: I = A in buck mode, else A - sqrt(val), saturate, drive the strobe
  // --------------------------------------------------------------------------
  eqc_sqrt_t        sq_last;
  logic [RootW-1:0] cur_full;
  logic             sat;
  eqc_out_t         res_d, res_q;
  logic             done_q;

  always_comb begin
    sq_last  = sq_s[RootW];
    // The root never exceeds A, so the difference cannot wrap.
    cur_full = sq_last.side.buck ? sq_last.quo_a : sq_last.quo_a - sq_last.root;
    sat      = sq_last.side.sat | (cur_full > RootW'(CurMax));

    res_d.equilibrium_current = sat ? CurMax : cur_full[ValueW-1:0];
    res_d.equilibrium_voltage = sq_last.side.vref;
    res_d.saturated           = sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sq_last.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

[hdl/eqc_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eqc_div_cell: one quotient bit of three divisions
// Consumes one numerator bit per lane and hands the state to the next cell.
// ----------------------------------------------------------------------------
module eqc_div_cell import eqc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire eqc_div_t d_i,
  output eqc_div_t      q_o
);

  logic [DenAW:0] ta;
  logic [DenPW:0] tp;
  logic [DenQW:0] tq;
  logic [DenAW:0] da;
  logic [DenPW:0] dp;
  logic [DenQW:0] dq;
  logic           ge_a, ge_p, ge_q;
  eqc_div_t       data_d, data_q;
  logic           valid_q;

  always_comb begin
    ta   = {d_i.rem_a, d_i.sh_a[NumW-1]};
    tp   = {d_i.rem_p, d_i.sh_p[NumW-1]};
    tq   = {d_i.rem_q, d_i.sh_q[NumW-1]};
    ge_a = ta >= {1'b0, d_i.den_a};
    ge_p = tp >= {1'b0, d_i.den_p};
    ge_q = tq >= {1'b0, d_i.den_q};
    da   = ta - {1'b0, d_i.den_a};
    dp   = tp - {1'b0, d_i.den_p};
    dq   = tq - {1'b0, d_i.den_q};

    data_d       = d_i;
    data_d.rem_a = ge_a ? da[DenAW-1:0] : ta[DenAW-1:0];
    data_d.rem_p = ge_p ? dp[DenPW-1:0] : tp[DenPW-1:0];
    data_d.rem_q = ge_q ? dq[DenQW-1:0] : tq[DenQW-1:0];
    data_d.sh_a  = {d_i.sh_a[NumW-2:0], ge_a};
    data_d.sh_p  = {d_i.sh_p[NumW-2:0], ge_p};
    data_d.sh_q  = {d_i.sh_q[NumW-2:0], ge_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    q_o            = data_q;
    q_o.side.valid = valid_q;
  end

endmodule
`default_nettype wire

[hdl/eqc_sqrt_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eqc_sqrt_cell: one root bit of the restoring square root
// Consumes two radicand bits and hands the state to the next cell.
// ----------------------------------------------------------------------------
module eqc_sqrt_cell import eqc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire eqc_sqrt_t d_i,
  output eqc_sqrt_t      q_o
);

  logic [RootW+2:0] t;
  logic [RootW+2:0] trial;
  logic [RootW+2:0] diff;
  logic             ge;
  eqc_sqrt_t        data_d, data_q;
  logic             valid_q;

  always_comb begin
    t     = {d_i.rem, d_i.sh[RadW-1 -: 2]};
    trial = {1'b0, d_i.root, 2'b01};
    diff  = t - trial;
    ge    = t >= trial;

    data_d      = d_i;
    data_d.rem  = ge ? diff[RootW:0] : t[RootW:0];
    data_d.root = {d_i.root[RootW-2:0], ge};
    data_d.sh   = {d_i.sh[RadW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    q_o            = data_q;
    q_o.side.valid = valid_q;
  end

endmodule
`default_nettype wire

[bench/tb_converter_equilibrium_current_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_converter_equilibrium_current_unit: self-checking bench
// Programs the operating-point registers over APB in several phases, feeds
// directed and random samples through a queue-fed driver with random gaps,
// and checks every result against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_converter_equilibrium_current_unit import eqc_pkg::*; ();

  localparam int unsigned Latency   = NumW + RootW + 3;
  localparam int unsigned CycleCap  = 1500000;
  localparam logic [63:0] CurMaxW   = 64'(CurMax);
  localparam logic [63:0] ValueMask = (64'd1 << ValueW) - 1;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             start_i = 1'b0;
  eqc_in_t          item_i = '0;
  logic             busy_o;
  logic             done_o;
  eqc_out_t         result_o;

  converter_equilibrium_current_unit DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .start_i, .item_i, .busy_o, .done_o, .result_o
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the register file used by the predictor.
  logic [1:0]        sh_mode;
  logic              sh_use_est;
  logic [ValueW-1:0] sh_nominal;
  logic [ValueW-1:0] sh_series;
  logic [ValueW-1:0] sh_vref;

  eqc_in_t  pending_items[$];
  int       pending_gaps[$];
  eqc_out_t expected_points[$];
  int       n_errors = 0;
  int       n_cycles = 0;

  // floor(sqrt(x)) for x below 2^128
  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (128'(t) * 128'(t) <= x) r = t;
    end
    return r;
  endfunction

  // Steady-state operating point for one sample under the shadow registers.
  function automatic eqc_out_t operating_point(eqc_in_t it);
    eqc_out_t     o;
    logic [127:0] u, load, v, r, a, w, p, q, val, cur;
    logic         sat;
    u    = 128'(it.input_voltage);
    load = sh_use_est ? 128'(it.estimated_load) : 128'(sh_nominal);
    v    = 128'(sh_vref);
    r    = 128'(sh_series);
    sat  = 1'b0;
    if (load == 0 || (sh_mode != MODE_BUCK && r == 0)) begin
      cur = 128'(CurMaxW);
      sat = 1'b1;
    end else if (sh_mode == MODE_BUCK) begin
      cur = (v << FracW) / load;
    end else begin
      a = (u << FracW) / (2 * r);
      w = (sh_mode == MODE_BOOST) ? v * v : v * (v + u);
      p = (((u * u) << (2 * FracW)) / r) / (4 * r);
      q = ((w << (2 * FracW)) / r) / load;
      val = (p > q) ? p - q : 128'd0;
      cur = 128'(isqrt(val));
      cur = (cur <= a) ? a - cur : 128'd0;
    end
    if (cur > 128'(CurMaxW)) begin
      cur = 128'(CurMaxW);
      sat = 1'b1;
    end
    o.equilibrium_current = cur[ValueW-1:0];
    o.equilibrium_voltage = sh_vref;
    o.saturated = sat;
    return o;
  endfunction

  // Driver: pop the next sample and raise start_i once its gap has run out.
  int  gap_left = 0;
  bit  have_item = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_points.push_back(operating_point(item_i));
        have_item = 1'b0;
      end
      if (!have_item && pending_items.size() > 0) begin
        have_item = 1'b1;
        gap_left = pending_gaps.pop_front();
        item_i <= pending_items.pop_front();
      end
      if (have_item && gap_left == 0) begin
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
        if (have_item) gap_left--;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction.
  always @(posedge clk_i) begin
    eqc_out_t exp_pt;
    n_cycles++;
    if (rst_ni && done_o) begin
      if (expected_points.size() == 0) begin
        $error("result with no prediction waiting");
        n_errors++;
      end else begin
        exp_pt = expected_points.pop_front();
        if (result_o.equilibrium_current !== exp_pt.equilibrium_current) begin
          $error("equilibrium_current exp %0h got %0h",
                 exp_pt.equilibrium_current, result_o.equilibrium_current);
          n_errors++;
        end
        if (result_o.equilibrium_voltage !== exp_pt.equilibrium_voltage) begin
          $error("equilibrium_voltage exp %0h got %0h",
                 exp_pt.equilibrium_voltage, result_o.equilibrium_voltage);
          n_errors++;
        end
        if (result_o.saturated !== exp_pt.saturated) begin
          $error("saturated exp %0b got %0b", exp_pt.saturated, result_o.saturated);
          n_errors++;
        end
      end
    end
    if (n_cycles > CycleCap) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Write one register: setup then access cycle; pready is always high.
  task automatic reg_write(logic [2:0] idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AddrW'(idx) << 2; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegMode:    sh_mode = value[1:0];
      RegUseEst:  sh_use_est = value[0];
      RegNomLoad: sh_nominal = value[ValueW-1:0];
      RegSeries:  sh_series = value[ValueW-1:0];
      RegVref:    sh_vref = value[ValueW-1:0];
      default: ;
    endcase
  endtask

  // Hold until the pipeline is drained, then let stray cycles pass.
  task automatic drain();
    while (pending_items.size() > 0 || have_item || start_i || expected_points.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic queue_item(logic [ValueW-1:0] u, logic [ValueW-1:0] ld, int gap);
    eqc_in_t it;
    it.input_voltage = u;
    it.estimated_load = ld;
    pending_items.push_back(it);
    pending_gaps.push_back(gap);
  endtask

  // Random value biased toward small magnitudes and the extremes.
  function automatic logic [ValueW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return ValueW'($urandom);
      1: return ValueW'($urandom_range(0, 4));
      2: return ValueW'(ValueMask) - ValueW'($urandom_range(0, 3));
      default: return ValueW'($urandom_range(1 << (FracW - 4), 40 << FracW));
    endcase
  endfunction

  function automatic int rand_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  initial begin
    sh_mode = MODE_BUCK; sh_use_est = 1'b0;
    sh_nominal = OneFix; sh_series = OneFix; sh_vref = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, then each mode with extremes and zero loads.
    queue_item('0, '0, 0);
    queue_item(ValueW'(ValueMask), ValueW'(ValueMask), 0);
    drain();
    reg_write(RegVref, 32'hFF00_0000 | (12 << FracW));
    reg_write(RegUseEst, 32'd1);
    for (int m = 0; m < 4; m++) begin
      reg_write(RegMode, 32'(m));
      queue_item(ValueW'(48 << FracW), ValueW'(10 << FracW), 0);
      queue_item(ValueW'(ValueMask), ValueW'(1), 1);
      queue_item('0, '0, 0);
      queue_item(ValueW'(5 << FracW), ValueW'(ValueMask), 2);
      drain();
    end
    reg_write(RegSeries, 32'd0);
    queue_item(ValueW'(24 << FracW), ValueW'(3 << FracW), 0);
    drain();
    reg_write(RegMode, MODE_BUCK);
    queue_item(ValueW'(24 << FracW), ValueW'(3 << FracW), 0);
    drain();
    reg_write(RegNomLoad, 32'd0);
    reg_write(RegUseEst, 32'd0);
    queue_item(ValueW'(24 << FracW), ValueW'(3 << FracW), 0);
    drain();

    // Random phases: fresh settings per phase, extremes included.
    for (int ph = 0; ph < 27; ph++) begin
      reg_write(RegMode, $urandom);
      reg_write(RegUseEst, $urandom);
      reg_write(RegNomLoad, (ph == 3) ? 32'hFFFF_FFFF : (ph == 5) ? 32'd1 : 32'(rand_value()));
      reg_write(RegSeries, (ph == 4) ? 32'hFFFF_FFFF : (ph == 6) ? 32'd1
                           : 32'($urandom_range(1 << 10, 4 << FracW)));
      reg_write(RegVref, (ph == 7) ? 32'hFFFF_FFFF : (ph == 8) ? 32'd0 : 32'(rand_value()));
      for (int k = 0; k < 50; k++)
        queue_item(rand_value(), rand_value(), (ph % 4 == 0) ? 0 : rand_gap());
      drain();
    end
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
